[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RPLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication checked on the following clock edge.
`define RPLS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/rpls_pkg.sv]
// ----------------------------------------------------------------------------
// rpls_pkg
// Types, constants and phase encoding for the record/playback link sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rpls_pkg;

    localparam int NAME_BYTES = 10;
    localparam int TIME_BYTES = 5;

    // Byte counts fixed by the payload fields
    localparam int NAME_OUT_BYTES = 10;
    localparam int TIME_OUT_BYTES = 5;

    localparam int POS_MAX     = (NAME_BYTES > TIME_BYTES) ? NAME_BYTES : TIME_BYTES;
    localparam int POS_W       = $clog2(POS_MAX + 1);
    localparam int LEN_W       = $clog2(NAME_BYTES + 1);
    localparam int NAME_IDX_W  = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int TIME_IDX_W  = (TIME_BYTES > 1) ? $clog2(TIME_BYTES) : 1;

    localparam logic [1:0] OP_POLL = 2'd0;
    localparam logic [1:0] OP_REC  = 2'd1;
    localparam logic [1:0] OP_PLAY = 2'd2;

    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_K   = 8'h4B;
    localparam logic [7:0] CH_P   = 8'h50;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    // APB register index (paddr bit 3 selects the 64-bit slot)
    localparam logic REG_PB_NAME_LOW  = 1'b0;
    localparam logic REG_PB_NAME_HIGH = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_REC_SEND_D = 4'd1,
        PH_REC_LEN    = 4'd2,
        PH_REC_NAME   = 4'd3,
        PH_REC_TIME   = 4'd4,
        PH_REC_WAIT_K = 4'd5,
        PH_REC_STREAM = 4'd6,
        PH_REC_END_K  = 4'd7,
        PH_PB_SEND_P  = 4'd8,
        PH_PB_WAIT_K  = 4'd9,
        PH_PB_NAME    = 4'd10,
        PH_PB_WAIT_F  = 4'd11
    } phase_t;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [POS_W:0]   pos_ext_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        tx_ready;
        logic        mic_valid;
        logic [7:0]  mic_sample;
        logic [39:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        busy_res;
        logic        save_strobe;
        logic [3:0]  save_length;
        logic [63:0] save_name_low;
        logic [15:0] save_name_high;
        logic [39:0] save_time;
    } res_item_t;

    typedef struct packed {
        phase_t phase;
        len_t   name_length;
        pos_t   byte_position;
    } seq_state_t;

    // Update handed from the step logic to the state registers
    typedef struct packed {
        seq_state_t nxt;
        logic       name_we;
        logic       time_we;
        logic [7:0] wr_byte;
    } seq_upd_t;

endpackage

`default_nettype wire

[sv/rpls_step.sv]
// ----------------------------------------------------------------------------
// rpls_step
// One sequencer step: next state, store writes and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_step (
    input  rpls_pkg::in_item_t              item,
    input  rpls_pkg::seq_state_t            st,
    input  logic [8*rpls_pkg::NAME_BYTES-1:0] name_flat,
    input  logic [8*rpls_pkg::TIME_BYTES-1:0] time_flat,
    input  logic [63:0]                     pb_name_low,
    input  logic [15:0]                     pb_name_high,
    output rpls_pkg::seq_upd_t              upd,
    output rpls_pkg::res_item_t             res
);
    import rpls_pkg::*;

    logic [79:0] pb_flat;
    logic [7:0]  pb_byte;
    logic [7:0]  time_byte;
    logic [7:0]  rx_len;
    pos_ext_t    pos_inc;
    logic        txv;
    logic [7:0]  txb;
    logic        save;
    logic [8*NAME_OUT_BYTES-1:0] save_name;
    logic [8*TIME_OUT_BYTES-1:0] save_tm;

    assign pb_flat = {pb_name_high, pb_name_low};
    assign pos_inc = pos_ext_t'(st.byte_position) + pos_ext_t'(1);
    assign rx_len  = (item.rx_byte > 8'(NAME_BYTES)) ? 8'(NAME_BYTES) : item.rx_byte;

    always_comb begin
        pb_byte = CH_NUL;
        if (int'(st.byte_position) < NAME_BYTES && int'(st.byte_position) < NAME_OUT_BYTES) begin
            pb_byte = pb_flat[8*st.byte_position +: 8];
        end
    end

    always_comb begin
        time_byte = 8'h00;
        if (int'(st.byte_position) < TIME_OUT_BYTES) begin
            time_byte = item.time_now[8*st.byte_position +: 8];
        end
    end

    always_comb begin
        upd.nxt     = st;
        upd.name_we = 1'b0;
        upd.time_we = 1'b0;
        upd.wr_byte = item.rx_byte;
        txv         = 1'b0;
        txb         = 8'h00;
        save        = 1'b0;

        if (item.op == OP_REC || item.op == OP_PLAY) begin
            upd.nxt.phase         = (item.op == OP_REC) ? PH_REC_SEND_D : PH_PB_SEND_P;
            upd.nxt.name_length   = '0;
            upd.nxt.byte_position = '0;
        end else begin
            unique case (st.phase)
                PH_IDLE: begin
                end
                PH_REC_SEND_D: begin
                    if (item.tx_ready) begin
                        txv           = 1'b1;
                        txb           = CH_D;
                        upd.nxt.phase = PH_REC_LEN;
                    end
                end
                PH_PB_SEND_P: begin
                    if (item.tx_ready) begin
                        txv           = 1'b1;
                        txb           = CH_P;
                        upd.nxt.phase = PH_PB_WAIT_K;
                    end
                end
                PH_REC_LEN: begin
                    if (item.rx_valid) begin
                        upd.nxt.name_length   = rx_len[LEN_W-1:0];
                        upd.nxt.byte_position = '0;
                        // zero length skips the name
                        upd.nxt.phase = (rx_len == 8'h00) ? PH_REC_TIME : PH_REC_NAME;
                    end
                end
                PH_REC_NAME: begin
                    if (item.rx_valid) begin
                        upd.name_we = (int'(st.byte_position) < NAME_BYTES);
                        if (pos_inc >= pos_ext_t'(st.name_length)) begin
                            upd.nxt.byte_position = '0;
                            upd.nxt.phase         = PH_REC_TIME;
                        end else begin
                            upd.nxt.byte_position = pos_inc[POS_W-1:0];
                        end
                    end
                end
                PH_REC_TIME: begin
                    if (item.tx_ready) begin
                        upd.time_we = (int'(st.byte_position) < TIME_BYTES);
                        upd.wr_byte = time_byte;
                        txv         = 1'b1;
                        txb         = time_byte;
                        if (pos_inc >= pos_ext_t'(TIME_BYTES)) begin
                            upd.nxt.byte_position = '0;
                            upd.nxt.phase         = PH_REC_WAIT_K;
                        end else begin
                            upd.nxt.byte_position = pos_inc[POS_W-1:0];
                        end
                    end
                end
                PH_REC_WAIT_K: begin
                    if (item.rx_valid && item.rx_byte == CH_K) begin
                        upd.nxt.phase = PH_REC_STREAM;
                    end
                end
                PH_PB_WAIT_K: begin
                    if (item.rx_valid && item.rx_byte == CH_K) begin
                        upd.nxt.phase = PH_PB_NAME;
                    end
                end
                PH_REC_STREAM: begin
                    // any host byte ends the stream; a sample can still go out
                    if (item.rx_valid) begin
                        upd.nxt.phase = PH_REC_END_K;
                    end
                    if (item.tx_ready && item.mic_valid) begin
                        txv = 1'b1;
                        txb = item.mic_sample;
                    end
                end
                PH_REC_END_K: begin
                    if (item.rx_valid && item.rx_byte == CH_K) begin
                        save          = 1'b1;
                        upd.nxt.phase = PH_IDLE;
                    end
                end
                PH_PB_NAME: begin
                    if (item.tx_ready) begin
                        txv = 1'b1;
                        txb = pb_byte;
                        if (int'(st.byte_position) >= NAME_BYTES || pb_byte == CH_NUL) begin
                            upd.nxt.byte_position = '0;
                            upd.nxt.phase         = PH_PB_WAIT_F;
                        end else begin
                            upd.nxt.byte_position = pos_inc[POS_W-1:0];
                        end
                    end
                end
                PH_PB_WAIT_F: begin
                    if (item.rx_valid && item.rx_byte == CH_F) begin
                        upd.nxt.phase = PH_IDLE;
                    end
                end
                default: begin
                    upd.nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

    // Name bytes at and beyond the length read as zero
    always_comb begin
        save_name = '0;
        for (int k = 0; k < NAME_OUT_BYTES; k++) begin
            if (k < NAME_BYTES && k < int'(st.name_length)) begin
                save_name[8*k +: 8] = name_flat[8*k +: 8];
            end
        end
    end

    always_comb begin
        save_tm = '0;
        for (int k = 0; k < TIME_OUT_BYTES; k++) begin
            if (k < TIME_BYTES) begin
                save_tm[8*k +: 8] = time_flat[8*k +: 8];
            end
        end
    end

    always_comb begin
        res.tx_valid       = txv;
        res.tx_byte        = txb;
        res.busy_res       = (upd.nxt.phase != PH_IDLE);
        res.save_strobe    = save;
        res.save_length    = save ? 4'(st.name_length) : 4'd0;
        res.save_name_low  = save ? save_name[63:0] : 64'd0;
        res.save_name_high = save ? save_name[79:64] : 16'd0;
        res.save_time      = save ? save_tm : 40'd0;
    end

endmodule

`default_nettype wire

[sv/rpls_state.sv]
// ----------------------------------------------------------------------------
// rpls_state
// Sequencer state registers with the received-name and sent-time stores.
// ----------------------------------------------------------------------------
`default_nettype none

module rpls_state (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  rpls_pkg::seq_upd_t              upd,
    output rpls_pkg::seq_state_t            st,
    output logic [8*rpls_pkg::NAME_BYTES-1:0] name_flat,
    output logic [8*rpls_pkg::TIME_BYTES-1:0] time_flat
);
    import rpls_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    logic [7:0] name_store_reg [NAME_BYTES];
    logic [7:0] time_store_reg [TIME_BYTES];

    assign state_next = advance ? upd.nxt : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.name_length   <= '0;
            state_reg.byte_position <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    // Stores are written at the current byte position
    always_ff @(posedge aclk) begin
        if (advance && upd.name_we) begin
            name_store_reg[state_reg.byte_position[NAME_IDX_W-1:0]] <= upd.wr_byte;
        end
        if (advance && upd.time_we) begin
            time_store_reg[state_reg.byte_position[TIME_IDX_W-1:0]] <= upd.wr_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < NAME_BYTES; k++) begin
            name_flat[8*k +: 8] = name_store_reg[k];
        end
        for (int k = 0; k < TIME_BYTES; k++) begin
            time_flat[8*k +: 8] = time_store_reg[k];
        end
    end

    assign st = state_reg;

endmodule

`default_nettype wire

[sv/record_playback_link_sequencer_core.sv]
// ----------------------------------------------------------------------------
// record_playback_link_sequencer_core
// Host-link record/playback sequencer, one step per accepted item.
// ----------------------------------------------------------------------------
//  channel   ports              direction  contents
//  s_        s_valid/s_ready    in         one poll or start command
//  m_        m_valid/m_ready    out        one result per item
//  apb       psel..prdata       in/out     playback name registers
//
//  One item per cycle sustained while m_ready is high; m_valid rises after each step.
//  The item register and the result register each hold one item; while a
//  result waits on m_ready the input takes one more item, then stalls.
//  Synchronous reset clears the phase and counters; name/time stores are not
//  cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module record_playback_link_sequencer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rpls_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rpls_pkg::res_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpls_pkg::APB_AW-1:0]  paddr,
    input  logic [rpls_pkg::APB_DW-1:0]  pwdata,
    output logic [rpls_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import rpls_pkg::*;

    logic        in_vld_reg;
    in_item_t    in_item_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    res_item_t   out_item_reg;
    logic [63:0] pb_low_reg;
    logic [15:0] pb_high_reg;
    logic        advance;
    logic        apb_wr;
    seq_state_t  st;
    seq_upd_t    upd;
    res_item_t   res;
    logic [8*NAME_BYTES-1:0] name_flat;
    logic [8*TIME_BYTES-1:0] time_flat;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_low_reg  <= '0;
            pb_high_reg <= '0;
        end else if (apb_wr) begin
            if (paddr[3] == REG_PB_NAME_LOW) begin
                pb_low_reg <= pwdata[63:0];
            end else begin
                pb_high_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_PB_NAME_HIGH) ? {48'd0, pb_high_reg} : pb_low_reg;

    // ---- item register ----
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    rpls_step u_step (
        .item         (in_item_reg),
        .st           (st),
        .name_flat    (name_flat),
        .time_flat    (time_flat),
        .pb_name_low  (pb_low_reg),
        .pb_name_high (pb_high_reg),
        .upd          (upd),
        .res          (res)
    );

    rpls_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .upd       (upd),
        .st        (st),
        .name_flat (name_flat),
        .time_flat (time_flat)
    );

    // ---- result register ----
    assign out_vld_next = advance || (out_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

    // ---- assertions ----
    `RPLS_ASSERT(a_save_idle, !(m_valid && m_data.save_strobe && m_data.busy_res), "save while busy")
    `RPLS_ASSERT(a_tx_zero, !(m_valid && !m_data.tx_valid && m_data.tx_byte != 8'h00), "tx_byte without tx_valid")
    `RPLS_ASSERT_NEXT(a_save_phase, advance && res.save_strobe, st.phase == PH_IDLE, "phase not idle after save")
    `RPLS_ASSERT_NEXT(a_adv_result, advance, m_valid, "advanced item produced no result")

endmodule

`default_nettype wire

[tb/record_playback_link_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_playback_link_sequencer_core_tb
// Drives poll and start items through the sequencer. A short directed table
// covers the field extremes and the corner cases of each phase. Random record
// and playback sessions follow under four playback-name settings. Every result
// is compared against a checked row's values or a cycle-free model in this file.
// ----------------------------------------------------------------------------

module record_playback_link_sequencer_core_tb;

    import rpls_pkg::*;

    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam int         DIR_N     = 27;
    localparam int         SET_ITEMS = 500;
    localparam int         LONG_HOLD = 300;
    localparam int         WDOG_MAX  = 4000;

    typedef struct {
        in_item_t  item;
        bit        chk;
        res_item_t res;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    res_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // model state
    phase_t      seq_ph;
    logic [3:0]  seq_len;
    logic [3:0]  seq_pos;
    logic [7:0]  name_mem [NAME_BYTES];
    logic [7:0]  stamp_mem [TIME_BYTES];
    logic [63:0] pb_lo;
    logic [15:0] pb_hi;

    res_item_t   pending_res [$];
    dir_row_t    dir_tab [DIR_N];
    res_item_t   want;
    logic        bad;
    int          n_in;
    int          n_out;
    int          mismatches;
    int          stall_cycles;
    bit          gaps_on;
    bit          stall_on;
    bit          steady_tail;
    bit          hold_req;
    bit          hold_done;

    record_playback_link_sequencer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // One step of the sequencer; updates the model state and returns the result.
    function automatic res_item_t step_sequencer(input in_item_t it);
        res_item_t   r;
        logic [7:0]  b;
        logic [79:0] pb_name;
        logic        save;
        r    = '0;
        save = 1'b0;
        if (it.op == OP_REC || it.op == OP_PLAY) begin
            seq_ph  = (it.op == OP_REC) ? PH_REC_SEND_D : PH_PB_SEND_P;
            seq_len = '0;
            seq_pos = '0;
        end else begin
            case (seq_ph)
                PH_IDLE: ;
                PH_REC_SEND_D, PH_PB_SEND_P: begin
                    if (it.tx_ready) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = (seq_ph == PH_REC_SEND_D) ? CH_D : CH_P;
                        seq_ph     = phase_t'(seq_ph + 1);
                    end
                end
                PH_REC_LEN: begin
                    if (it.rx_valid) begin
                        seq_len = (it.rx_byte > NAME_BYTES) ? 4'(NAME_BYTES) : it.rx_byte[3:0];
                        seq_pos = '0;
                        seq_ph  = (seq_len == 0) ? PH_REC_TIME : PH_REC_NAME;
                    end
                end
                PH_REC_NAME: begin
                    if (it.rx_valid) begin
                        if (seq_pos < NAME_BYTES) name_mem[seq_pos] = it.rx_byte;
                        if (seq_pos + 1 >= seq_len) begin
                            seq_pos = '0;
                            seq_ph  = PH_REC_TIME;
                        end else begin
                            seq_pos = seq_pos + 4'd1;
                        end
                    end
                end
                PH_REC_TIME: begin
                    if (it.tx_ready) begin
                        b                       = it.time_now[8*seq_pos +: 8];
                        stamp_mem[seq_pos[2:0]] = b;
                        r.tx_valid              = 1'b1;
                        r.tx_byte               = b;
                        if (seq_pos + 1 >= TIME_BYTES) begin
                            seq_pos = '0;
                            seq_ph  = PH_REC_WAIT_K;
                        end else begin
                            seq_pos = seq_pos + 4'd1;
                        end
                    end
                end
                PH_REC_WAIT_K, PH_PB_WAIT_K: begin
                    if (it.rx_valid && it.rx_byte == CH_K) seq_ph = phase_t'(seq_ph + 1);
                end
                PH_REC_STREAM: begin
                    // any host byte ends the stream, the sample still goes out
                    if (it.rx_valid) seq_ph = PH_REC_END_K;
                    if (it.tx_ready && it.mic_valid) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = it.mic_sample;
                    end
                end
                PH_REC_END_K: begin
                    if (it.rx_valid && it.rx_byte == CH_K) begin
                        save   = 1'b1;
                        seq_ph = PH_IDLE;
                    end
                end
                PH_PB_NAME: begin
                    if (it.tx_ready) begin
                        pb_name = {pb_hi, pb_lo};
                        b       = CH_NUL;
                        if (seq_pos < NAME_BYTES) b = pb_name[8*seq_pos +: 8];
                        r.tx_valid = 1'b1;
                        r.tx_byte  = b;
                        if (seq_pos >= NAME_BYTES || b == CH_NUL) begin
                            seq_pos = '0;
                            seq_ph  = PH_PB_WAIT_F;
                        end else begin
                            seq_pos = seq_pos + 4'd1;
                        end
                    end
                end
                PH_PB_WAIT_F: begin
                    if (it.rx_valid && it.rx_byte == CH_F) seq_ph = PH_IDLE;
                end
                default: seq_ph = PH_IDLE;
            endcase
        end
        r.busy_res = (seq_ph != PH_IDLE);
        if (save) begin
            r.save_strobe = 1'b1;
            r.save_length = seq_len;
            for (int k = 0; k < NAME_BYTES; k++) begin
                if (k < seq_len) begin
                    if (k < 8) r.save_name_low[8*k +: 8] = name_mem[k];
                    else       r.save_name_high[8*(k-8) +: 8] = name_mem[k];
                end
            end
            for (int k = 0; k < TIME_BYTES; k++) r.save_time[8*k +: 8] = stamp_mem[k];
        end
        return r;
    endfunction

    function automatic in_item_t mk(input logic [1:0] op, input int rxv,
                                    input logic [7:0] rxb, input int txr,
                                    input int micv, input logic [7:0] mic,
                                    input logic [39:0] tnow);
        in_item_t it;
        it.op         = op;
        it.rx_valid   = 1'(rxv);
        it.rx_byte    = rxb;
        it.tx_ready   = 1'(txr);
        it.mic_valid  = 1'(micv);
        it.mic_sample = mic;
        it.time_now   = tnow;
        return it;
    endfunction

    function automatic dir_row_t row(input in_item_t it, input int chk, input int tv,
                                     input logic [7:0] tb, input int busy);
        dir_row_t d;
        d.item           = it;
        d.chk            = (chk != 0);
        d.res            = '0;
        d.res.tx_valid   = 1'(tv);
        d.res.tx_byte    = tb;
        d.res.busy_res   = 1'(busy);
        return d;
    endfunction

    // Random item shaped by the phase the sequencer is in, so that most
    // sessions run to their end; a share is noise or stray starts.
    function automatic in_item_t next_link_item();
        in_item_t it;
        int       r;
        it.op         = OP_POLL;
        it.rx_valid   = 1'($urandom_range(0, 1));
        it.rx_byte    = 8'($urandom);
        it.tx_ready   = 1'($urandom_range(0, 1));
        it.mic_valid  = 1'($urandom_range(0, 1));
        it.mic_sample = 8'($urandom);
        it.time_now   = {8'($urandom), 32'($urandom)};
        r = $urandom_range(0, 99);
        if (r < 8) begin
            it.op = 2'($urandom_range(0, 3));
        end else if (r < 10) begin
            it.op = ($urandom_range(0, 1) != 0) ? OP_REC : OP_PLAY;
        end else begin
            case (seq_ph)
                PH_IDLE: it.op = (r < 50) ? OP_REC : ((r < 85) ? OP_PLAY : OP_POLL);
                PH_REC_SEND_D, PH_PB_SEND_P, PH_REC_TIME, PH_PB_NAME:
                    it.tx_ready = (r < 80);
                PH_REC_LEN: begin
                    it.rx_valid = (r < 75);
                    if (r < 65) it.rx_byte = 8'($urandom_range(0, 12));
                end
                PH_REC_NAME: it.rx_valid = (r < 75);
                PH_REC_WAIT_K, PH_PB_WAIT_K, PH_REC_END_K: begin
                    it.rx_valid = (r < 70);
                    if (r < 60) it.rx_byte = CH_K;
                end
                PH_PB_WAIT_F: begin
                    it.rx_valid = (r < 70);
                    if (r < 60) it.rx_byte = CH_F;
                end
                PH_REC_STREAM: it.rx_valid = (r < 16);
                default: ;
            endcase
        end
        return it;
    endfunction

    function automatic string fmt_res(input res_item_t r);
        return $sformatf("tx %0b/%02h busy %0b save %0b len %0d name %04h_%016h time %010h",
                         r.tx_valid, r.tx_byte, r.busy_res, r.save_strobe, r.save_length,
                         r.save_name_high, r.save_name_low, r.save_time);
    endfunction

    // entered and left at a falling edge
    task automatic put_item(input in_item_t it);
        if (!steady_tail) begin
            if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_name(input logic [63:0] lo, input logic [15:0] hi);
        apb_write({REG_PB_NAME_LOW, 3'b000}, lo);
        apb_write({REG_PB_NAME_HIGH, 3'b000}, {48'd0, hi});
        pb_lo = lo;
        pb_hi = hi;
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        while (pending_res.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // scoreboard: check results, predict each accepted item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with nothing outstanding: %s",
                                 n_out, fmt_res(m_data));
                end else begin
                    want = pending_res.pop_front();
                    bad  = (m_data.tx_valid       !== want.tx_valid)       ||
                           (m_data.tx_byte        !== want.tx_byte)        ||
                           (m_data.busy_res       !== want.busy_res)       ||
                           (m_data.save_strobe    !== want.save_strobe)    ||
                           (m_data.save_length    !== want.save_length)    ||
                           (m_data.save_name_low  !== want.save_name_low)  ||
                           (m_data.save_name_high !== want.save_name_high) ||
                           (m_data.save_time      !== want.save_time);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: expected %s, got %s",
                                     n_out, fmt_res(want), fmt_res(m_data));
                    end
                end
                n_out++;
            end
            if (s_valid && s_ready) begin
                want = step_sequencer(s_data);
                if (n_in < DIR_N && dir_tab[n_in].chk) want = dir_tab[n_in].res;
                pending_res.push_back(want);
                n_in++;
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WDOG_MAX) begin
                $display("record_playback_link_sequencer_core test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                // long hold so the block fills and stalls its input
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
                if (!steady_tail && stall_on && $urandom_range(0, 4) == 0) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [79:0] name80;
        in_item_t    it;
        int          n;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        aresetn      = 1'b0;
        seq_ph       = PH_IDLE;
        seq_len      = '0;
        seq_pos      = '0;
        pb_lo        = '0;
        pb_hi        = '0;
        n_in         = 0;
        n_out        = 0;
        mismatches   = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        stall_on     = 1'b1;
        steady_tail  = 1'b0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;

        dir_tab[0]  = row(mk(OP_POLL, 0, 8'h00, 0, 0, 8'h00, '0), 1, 0, 8'h00, 0);
        dir_tab[1]  = row(mk(OP_SPARE, 1, 8'hFF, 1, 1, 8'hFF, '1), 1, 0, 8'h00, 0);
        dir_tab[2]  = row(mk(OP_REC, 0, 8'h00, 0, 0, 8'h00, '0), 1, 0, 8'h00, 1);
        dir_tab[3]  = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 1, 1, CH_D, 1);
        dir_tab[4]  = row(mk(OP_POLL, 1, 8'hFF, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[5]  = row(mk(OP_POLL, 1, 8'h41, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        // restart while busy
        dir_tab[6]  = row(mk(OP_REC, 1, 8'h42, 1, 0, 8'h00, '0), 1, 0, 8'h00, 1);
        dir_tab[7]  = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 1, 1, CH_D, 1);
        // zero name length goes straight to the time bytes
        dir_tab[8]  = row(mk(OP_POLL, 1, 8'h00, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[9]  = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '1), 1, 1, 8'hFF, 1);
        dir_tab[10] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 1, 1, 8'h00, 1);
        dir_tab[11] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, 40'h12_3456_789A), 0, 0, 8'h00, 0);
        dir_tab[12] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, 40'hA5_A5A5_A5A5), 0, 0, 8'h00, 0);
        dir_tab[13] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '1), 1, 1, 8'hFF, 1);
        dir_tab[14] = row(mk(OP_POLL, 1, CH_K, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[15] = row(mk(OP_POLL, 0, 8'h00, 1, 1, 8'hFF, '0), 1, 1, 8'hFF, 1);
        // host byte ends the stream on the same step a sample goes out
        dir_tab[16] = row(mk(OP_POLL, 1, 8'h00, 1, 1, 8'h00, '0), 0, 0, 8'h00, 0);
        // 'K' without rx_valid must not finish the recording
        dir_tab[17] = row(mk(OP_POLL, 0, CH_K, 1, 1, 8'h55, '0), 0, 0, 8'h00, 0);
        dir_tab[18] = row(mk(OP_POLL, 1, CH_K, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[19] = row(mk(OP_PLAY, 0, 8'h00, 0, 0, 8'h00, '0), 1, 0, 8'h00, 1);
        dir_tab[20] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 1, 1, CH_P, 1);
        dir_tab[21] = row(mk(OP_POLL, 1, 8'h51, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[22] = row(mk(OP_POLL, 1, CH_K, 0, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[23] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[24] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[25] = row(mk(OP_POLL, 0, 8'h00, 1, 0, 8'h00, '0), 0, 0, 8'h00, 0);
        dir_tab[26] = row(mk(OP_POLL, 1, CH_F, 0, 0, 8'h00, '0), 1, 0, 8'h00, 0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // "AB" then a zero byte
        program_name(64'h0000_0000_0000_4241, 16'hFFFF);
        for (int i = 0; i < DIR_N; i++) put_item(dir_tab[i].item);

        for (int set = 0; set < 4; set++) begin
            s_valid <= 1'b0;
            drain();
            case (set)
                0: program_name('0, '0);
                1: program_name('1, '1);
                2: begin
                    name80 = {16'($urandom), 32'($urandom), 32'($urandom)};
                    name80[8*$urandom_range(0, NAME_BYTES-1) +: 8] = CH_NUL;
                    program_name(name80[63:0], name80[79:64]);
                end
                default: program_name({$urandom, $urandom}, 16'($urandom));
            endcase
            n = 0;
            while (n < SET_ITEMS) begin
                it = next_link_item();
                if (seq_ph != PH_IDLE || it.op == OP_REC || it.op == OP_PLAY) n++;
                if (set == 1 && n == 100) hold_req = 1'b1;
                if (set == 3 && n >= SET_ITEMS - 150) steady_tail = 1'b1;
                put_item(it);
            end
        end
        s_valid <= 1'b0;
        drain();

        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("record_playback_link_sequencer_core test passed");
        end else begin
            $display("record_playback_link_sequencer_core test failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/rpls_pkg.sv
sv/rpls_step.sv
sv/rpls_state.sv
sv/record_playback_link_sequencer_core.sv
tb/record_playback_link_sequencer_core_tb.sv
